/* hw/rtl/pinhole_point_projection_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the pinhole projection block.
// ---------------------------------------------------------------------------
`ifndef PINHOLE_POINT_PROJECTION_DEFINES_SVH
`define PINHOLE_POINT_PROJECTION_DEFINES_SVH
`ifndef ASSERT_OFF
`define PPP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define PPP_ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define PPP_ASSERT(label, clk, rst_n, prop)
`define PPP_ASSERT_NORST(label, clk, prop)
`endif
`endif

/* hw/rtl/ppp_pkg.sv */
// ---------------------------------------------------------------------------
// Pinhole projection package
// Shared constants and register index codes.
// ---------------------------------------------------------------------------
package ppp_pkg;
  localparam int COORD_FRAC_BITS = 16;
  localparam int VEC_W = 21;
  localparam int VEC_FRAC = 19;
  localparam int FOCAL_FRAC = 16;
  localparam int QUOT_CAP_BITS = 40;

  typedef enum logic [2:0] {
    REG_CAM_X  = 3'd0,
    REG_CAM_Y  = 3'd1,
    REG_CAM_Z  = 3'd2,
    REG_FWD    = 3'd3,
    REG_UP     = 3'd4,
    REG_FOCAL  = 3'd5,
    REG_IMG_W  = 3'd6,
    REG_IMG_H  = 3'd7
  } reg_idx_t;
endpackage

/* hw/rtl/ppp_div.sv */
// ---------------------------------------------------------------------------
// Pipelined restoring divider
// Unsigned magnitude divide, one quotient bit per stage, remainder kept.
// ---------------------------------------------------------------------------
module ppp_div #(
  parameter int NW = 64,
  parameter int DW = 32,
  parameter int TW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [TW-1:0] tag_in,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem,
  output logic [DW-1:0] den_out,
  output logic [TW-1:0] tag_out
);
  // Each stage holds partial remainder, shifted numerator and divisor.
  logic [DW:0]   r_r   [NW+1];
  logic [NW-1:0] n_r   [NW+1];
  logic [DW-1:0] d_r   [NW+1];
  logic [TW-1:0] t_r   [NW+1];

  always_comb begin
    r_r[0] = '0;
    n_r[0] = num;
    d_r[0] = den;
    t_r[0] = tag_in;
  end

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [DW:0]   r_nxt;
    logic [DW+1:0] trial;
    logic [DW:0]   r_q;
    logic [NW-1:0] n_q;
    logic [DW-1:0] d_q;
    logic [TW-1:0] t_q;
    always_comb begin
      trial = {r_r[i], n_r[i][NW-1]};
      if (trial >= {2'b00, d_r[i]}) begin
        r_nxt = (DW+1)'(trial - {2'b00, d_r[i]});
      end else begin
        r_nxt = trial[DW:0];
      end
    end
    // Quotient bits shift in at the bottom as numerator bits leave the top.
    always_ff @(posedge clk) begin
      if (en) begin
        r_q <= r_nxt;
        n_q <= {n_r[i][NW-2:0], (trial >= {2'b00, d_r[i]})};
        d_q <= d_r[i];
        t_q <= t_r[i];
      end
    end
    always_comb begin
      r_r[i+1] = r_q;
      n_r[i+1] = n_q;
      d_r[i+1] = d_q;
      t_r[i+1] = t_q;
    end
  end

  assign quo = n_r[NW];
  assign rem = r_r[NW][DW-1:0];
  assign den_out = d_r[NW];
  assign tag_out = t_r[NW];

  logic unused_rst;
  assign unused_rst = rst_n;
endmodule

/* hw/rtl/pinhole_point_projection.sv */
// The pipeline holds 4 + 64 + 4 = 72 register stages from input beat to result beat.
// Throughput: one point per cycle while the output is not stalled; the long divide is a bit-per-stage pipeline.
// The whole pipeline advances together; a stalled output holds every stage.
// Reset (rst_n low, synchronous) clears valid bits and loads register defaults.
// ---------------------------------------------------------------------------
// Pinhole point projection
// Projects world points through a configurable pinhole camera.
// ---------------------------------------------------------------------------
`include "pinhole_point_projection_defines.svh"
module pinhole_point_projection
  import ppp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // point_x [31:0], point_y [63:32], point_z [95:64]
  input  logic [95:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // view_u, view_v, pixel_x, pixel_y, depth (32 each), not_in_front [160], pad
  output logic [167:0] out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [5:0]   cfg_paddr,
  input  logic [63:0]  cfg_pwdata,
  output logic [63:0]  cfg_prdata,
  output logic         cfg_pready
);
  localparam int F = COORD_FRAC_BITS;
  localparam int NW = 64;
  localparam int DW = 40;

  // Configuration registers.
  logic [31:0] cam_x_r, cam_y_r, cam_z_r;
  logic [62:0] fwd_r, up_r;
  logic [23:0] focal_r;
  logic [15:0] img_w_r, img_h_r;
  logic        wr;
  reg_idx_t    widx;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel & cfg_penable & cfg_pwrite;
  assign widx = reg_idx_t'(cfg_paddr[5:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r <= '0; cam_y_r <= '0; cam_z_r <= '0;
      fwd_r <= 63'd1572864; up_r <= 63'd1099511627776;
      focal_r <= 24'd65536; img_w_r <= 16'd640; img_h_r <= 16'd480;
    end else if (wr && cfg_paddr[2:0] == 3'd0) begin
      case (widx)
        REG_CAM_X: cam_x_r <= cfg_pwdata[31:0];
        REG_CAM_Y: cam_y_r <= cfg_pwdata[31:0];
        REG_CAM_Z: cam_z_r <= cfg_pwdata[31:0];
        REG_FWD:   fwd_r   <= cfg_pwdata[62:0];
        REG_UP:    up_r    <= cfg_pwdata[62:0];
        REG_FOCAL: focal_r <= cfg_pwdata[23:0];
        REG_IMG_W: img_w_r <= cfg_pwdata[15:0];
        REG_IMG_H: img_h_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (widx)
      REG_CAM_X: cfg_prdata = {32'd0, cam_x_r};
      REG_CAM_Y: cfg_prdata = {32'd0, cam_y_r};
      REG_CAM_Z: cfg_prdata = {32'd0, cam_z_r};
      REG_FWD:   cfg_prdata = {1'b0, fwd_r};
      REG_UP:    cfg_prdata = {1'b0, up_r};
      REG_FOCAL: cfg_prdata = {40'd0, focal_r};
      REG_IMG_W: cfg_prdata = {48'd0, img_w_r};
      REG_IMG_H: cfg_prdata = {48'd0, img_h_r};
      default:   cfg_prdata = '0;
    endcase
  end

  // Global pipeline enable: everything moves when the output can drain.
  logic en;
  assign en = out_tready | ~out_tvalid;
  assign in_tready = en;

  // Vector fields.
  logic signed [20:0] fx, fy, fz, ux, uy, uz;
  assign fx = fwd_r[62:42]; assign fy = fwd_r[41:21]; assign fz = fwd_r[20:0];
  assign ux = up_r[62:42];  assign uy = up_r[41:21];  assign uz = up_r[20:0];

  // Right vector from config, registered (the user must keep config static while busy; the block does not enforce it).
  logic signed [42:0] cx, cy, cz;
  logic signed [23:0] rx_r, ry_r, rz_r;
  always_comb begin
    cx = 43'(fy * uz) - 43'(fz * uy) + 43'sd262144;
    cy = 43'(fz * ux) - 43'(fx * uz) + 43'sd262144;
    cz = 43'(fx * uy) - 43'(fy * ux) + 43'sd262144;
  end
  always_ff @(posedge clk) begin
    rx_r <= 24'(cx >>> VEC_FRAC);
    ry_r <= 24'(cy >>> VEC_FRAC);
    rz_r <= 24'(cz >>> VEC_FRAC);
  end

  // Stage 1: offsets.
  logic        v1_r;
  logic signed [32:0] ox_r, oy_r, oz_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_tvalid;
    if (en) begin
      ox_r <= 33'(signed'(in_tdata[31:0]))  - 33'(signed'(cam_x_r));
      oy_r <= 33'(signed'(in_tdata[63:32])) - 33'(signed'(cam_y_r));
      oz_r <= 33'(signed'(in_tdata[95:64])) - 33'(signed'(cam_z_r));
    end
  end

  // Stage 2: nine products.
  logic v2_r;
  logic signed [56:0] pd_r [3];
  logic signed [56:0] pu_r [3];
  logic signed [57:0] pr_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
    if (en) begin
      pd_r[0] <= 57'(ox_r * fx); pd_r[1] <= 57'(oy_r * fy); pd_r[2] <= 57'(oz_r * fz);
      pu_r[0] <= 57'(ox_r * ux); pu_r[1] <= 57'(oy_r * uy); pu_r[2] <= 57'(oz_r * uz);
      pr_r[0] <= 58'(ox_r * rx_r); pr_r[1] <= 58'(oy_r * ry_r);
      pr_r[2] <= 58'(oz_r * rz_r);
    end
  end

  // Stage 3: sums and rounding to F fraction bits.
  localparam int RS = VEC_FRAC;
  logic v3_r;
  logic signed [59:0] dsum, usum, rsum;
  logic signed [40:0] dep_r, ty_r, tx_r;
  always_comb begin
    dsum = 60'(pd_r[0]) + 60'(pd_r[1]) + 60'(pd_r[2]) + 60'sd262144;
    usum = 60'(pu_r[0]) + 60'(pu_r[1]) + 60'(pu_r[2]) + 60'sd262144;
    rsum = 60'(pr_r[0]) + 60'(pr_r[1]) + 60'(pr_r[2]) + 60'sd262144;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
    if (en) begin
      dep_r <= 41'(dsum >>> RS);
      ty_r  <= 41'(usum >>> RS);
      tx_r  <= 41'(rsum >>> RS);
    end
  end

  // Stage 4: focal products and magnitudes; the divisor is the full depth.
  logic v4_r, nf4_r, su4_r, sr4_r;
  logic [63:0] nu4_r, nr4_r;
  logic [DW-1:0] dd4_r;
  logic signed [31:0] dsat4_r;
  logic signed [65:0] fu, fr;
  always_comb begin
    fu = 66'(ty_r) * $signed({1'b0, focal_r});
    fr = 66'(tx_r) * $signed({1'b0, focal_r});
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (en) v4_r <= v3_r;
    if (en) begin
      nf4_r <= (dep_r <= 0);
      su4_r <= fu[65];
      sr4_r <= fr[65];
      nu4_r <= 64'(fu[65] ? -fu : fu);
      nr4_r <= 64'(fr[65] ? -fr : fr);
      dd4_r <= (dep_r <= 0) ? DW'(1) : DW'(dep_r);
      dsat4_r <= (dep_r > 41'sd2147483647) ? 32'sh7fffffff : 32'(dep_r);
    end
  end

  // Divider; sideband carries the flags and saturated depth.
  localparam int TW = 35;
  logic [NW-1:0] qu, qr;
  logic [DW-1:0] remu, remr, dno, dno2;
  logic [TW-1:0] tgu, tgr;
  ppp_div #(.NW(NW), .DW(DW), .TW(TW)) u_div_u (
    .clk, .rst_n, .en, .num(nu4_r), .den(dd4_r),
    .tag_in({nf4_r, su4_r, sr4_r, dsat4_r}),
    .quo(qu), .rem(remu), .den_out(dno), .tag_out(tgu));
  ppp_div #(.NW(NW), .DW(DW), .TW(TW)) u_div_r (
    .clk, .rst_n, .en, .num(nr4_r), .den(dd4_r),
    .tag_in({nf4_r, su4_r, sr4_r, dsat4_r}),
    .quo(qr), .rem(remr), .den_out(dno2), .tag_out(tgr));

  // Valid bits that follow the divider stages.
  logic [NW-1:0] vdiv_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vdiv_r <= '0;
    else if (en) vdiv_r <= {vdiv_r[NW-2:0], v4_r};
  end

  // Stage 5: round the quotient and clamp it.
  localparam logic [NW-1:0] CAP = NW'(1) << QUOT_CAP_BITS;
  logic v5_r, nf5_r;
  logic signed [31:0] dep5_r;
  logic signed [NW:0] vup5_r, vrt5_r;
  function automatic logic [NW-1:0] rnd_q(input logic [NW-1:0] q,
                                          input logic [DW-1:0] r,
                                          input logic [DW-1:0] d);
    logic [NW-1:0] res;
    res = ({r, 1'b0} >= {1'b0, d}) ? q + NW'(1) : q;
    if (q >= CAP) res = CAP;
    return res;
  endfunction
  logic [NW-1:0] mu, mr;
  always_comb begin
    mu = rnd_q(qu, remu, dno);
    mr = rnd_q(qr, remr, dno2);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (en) v5_r <= vdiv_r[NW-1];
    if (en) begin
      nf5_r <= tgu[34];
      dep5_r <= tgu[31:0];
      vup5_r <= tgu[33] ? -$signed({1'b0, mu}) : $signed({1'b0, mu});
      vrt5_r <= tgr[32] ? -$signed({1'b0, mr}) : $signed({1'b0, mr});
    end
  end

  // Stage 6: shift to upper-left origin and saturate.
  localparam logic signed [NW+1:0] HALF = (NW+2)'(1) << (F - 1);
  logic v6_r, nf6_r;
  logic signed [31:0] vu6_r, vv6_r, dep6_r;
  logic signed [NW+1:0] su, sv;
  function automatic logic signed [31:0] sat(input logic signed [NW+1:0] x);
    if (x > (NW+2)'(64'sh7fffffff)) return 32'sh7fffffff;
    if (x < -(NW+2)'(64'sh80000000)) return 32'sh80000000;
    return 32'(x);
  endfunction
  always_comb begin
    su = (NW+2)'(vrt5_r) + HALF;
    sv = HALF - (NW+2)'(vup5_r);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else if (en) v6_r <= v5_r;
    if (en) begin
      nf6_r <= nf5_r; dep6_r <= dep5_r;
      vu6_r <= sat(su); vv6_r <= sat(sv);
    end
  end

  // Stage 7: pixel products.
  logic v7_r, nf7_r;
  logic signed [31:0] vu7_r, vv7_r, dep7_r;
  logic signed [48:0] px7_r, py7_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v7_r <= 1'b0;
    else if (en) v7_r <= v6_r;
    if (en) begin
      nf7_r <= nf6_r; dep7_r <= dep6_r; vu7_r <= vu6_r; vv7_r <= vv6_r;
      px7_r <= 49'(vu6_r) * $signed({1'b0, img_w_r});
      py7_r <= 49'(vv6_r) * $signed({1'b0, img_h_r});
    end
  end

  // Stage 8: round half to even, saturate, zero when behind the camera.
  function automatic logic signed [31:0] pix(input logic signed [48:0] p);
    logic signed [48:0] q;
    logic [F-1:0] rm;
    q = p >>> F;
    rm = p[F-1:0];
    if (rm > (F)'(1) << (F - 1) || (rm == (F)'(1) << (F - 1) && q[0])) q = q + 49'sd1;
    if (q > 49'sd2147483647) return 32'sh7fffffff;
    if (q < -49'sd2147483648) return 32'sh80000000;
    return 32'(q);
  endfunction
  logic out_v_r;
  logic [167:0] out_d_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (en) out_v_r <= v7_r;
    if (en) begin
      if (nf7_r) out_d_r <= {7'd0, 1'b1, 160'd0};
      else out_d_r <= {7'd0, 1'b0, dep7_r, pix(py7_r), pix(px7_r), vv7_r, vu7_r};
    end
  end
  assign out_tvalid = out_v_r;
  assign out_tdata = out_d_r;

  // A stalled output keeps its beat.
  `PPP_ASSERT(a_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid)
  // Behind-camera beats carry zero fields.
  `PPP_ASSERT(a_zero, clk, rst_n, out_tvalid && out_tdata[160] |-> out_tdata[159:0] == '0)
  // The input side is ready whenever the output is free.
  `PPP_ASSERT(a_rdy, clk, rst_n, !out_tvalid |-> in_tready)
endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pinhole point projection testbench
// Streams world points through the projection block under several camera
// settings and compares every result beat with an in-bench projection.
// ----------------------------------------------------------------------------
module tb_top;
  import ppp_pkg::*;

  localparam int  FRAC = 16;
  localparam int  SETTLE = 200;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic        behind;
    logic [31:0] depth;
    logic [31:0] pix_y;
    logic [31:0] pix_x;
    logic [31:0] view_v;
    logic [31:0] view_u;
  } proj_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  // point_x, point_y, point_z
  logic [95:0]  in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // view_u, view_v, pixel_x, pixel_y, depth, not_in_front, pad
  logic [167:0] out_tdata;
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [5:0]   cfg_paddr = '0;
  logic [63:0]  cfg_pwdata = '0;
  logic [63:0]  cfg_prdata;
  logic         cfg_pready;

  pinhole_point_projection uut (.*);

  always #1 clk = ~clk;

  // Camera settings as the block should hold them.
  logic [31:0] cam_x, cam_y, cam_z;
  logic [62:0] fwd_vec, up_vec;
  logic [23:0] focal;
  logic [15:0] img_w, img_h;

  logic [95:0] pend_points[$];
  proj_t       exp_proj[$];
  int          errors = 0;
  int          hold_req = 0;
  logic        no_gaps = 1'b0;

  function automatic longint rnd19(longint x);
    return (x + (longint'(1) <<< 18)) >>> 19;
  endfunction

  function automatic longint sat32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // Rounded quotient, ties away from zero, magnitude capped at 2^40.
  function automatic longint round_div(longint n, longint d);
    longint m, q, r;
    m = (n < 0) ? -n : n;
    q = m / d;
    r = m % d;
    if (q >= (longint'(1) <<< 40)) q = longint'(1) <<< 40;
    else q = q + (2 * r + d) / (2 * d);
    return (n < 0) ? -q : q;
  endfunction

  // Scale down by 2^FRAC, ties to even, then saturate.
  function automatic longint pixel_round(longint prod);
    longint q, rem;
    q = prod >>> FRAC;
    rem = prod - (q <<< FRAC);
    if (rem > (longint'(1) <<< (FRAC - 1)) ||
        (rem == (longint'(1) <<< (FRAC - 1)) && q[0])) q++;
    return sat32(q);
  endfunction

  function automatic proj_t project(logic [95:0] pt);
    longint ox, oy, oz, fx, fy, fz, ux, uy, uz, rx, ry, rz;
    longint dep, ty, tx, vu, vv;
    proj_t  p;
    ox = longint'($signed(pt[31:0])) - longint'($signed(cam_x));
    oy = longint'($signed(pt[63:32])) - longint'($signed(cam_y));
    oz = longint'($signed(pt[95:64])) - longint'($signed(cam_z));
    fx = longint'($signed(fwd_vec[62:42]));
    fy = longint'($signed(fwd_vec[41:21]));
    fz = longint'($signed(fwd_vec[20:0]));
    ux = longint'($signed(up_vec[62:42]));
    uy = longint'($signed(up_vec[41:21]));
    uz = longint'($signed(up_vec[20:0]));
    rx = rnd19(fy * uz - fz * uy);
    ry = rnd19(fz * ux - fx * uz);
    rz = rnd19(fx * uy - fy * ux);
    dep = rnd19(ox * fx + oy * fy + oz * fz);
    ty = rnd19(ox * ux + oy * uy + oz * uz);
    tx = rnd19(ox * rx + oy * ry + oz * rz);
    p = '0;
    if (dep <= 0) begin
      p.behind = 1'b1;
      return p;
    end
    vu = sat32(round_div(longint'(focal) * tx, dep) + (longint'(1) <<< (FRAC - 1)));
    vv = sat32((longint'(1) <<< (FRAC - 1)) - round_div(longint'(focal) * ty, dep));
    p.view_u = vu[31:0];
    p.view_v = vv[31:0];
    p.pix_x = 32'(pixel_round(longint'(img_w) * vu));
    p.pix_y = 32'(pixel_round(longint'(img_h) * vv));
    p.depth = 32'(sat32(dep));
    return p;
  endfunction

  // Driver: one point per beat, random gap after each unless no_gaps is set.
  int gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) exp_proj.push_back(project(in_tdata));
      if (!in_tvalid || in_tready) begin
        if (gap > 0) begin
          gap <= gap - 1;
          in_tvalid <= 1'b0;
        end else if (pend_points.size() > 0) begin
          in_tdata <= pend_points.pop_front();
          in_tvalid <= 1'b1;
          gap <= no_gaps ? 0 : $urandom_range(0, 5);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure, long holds on request, field checks.
  int stall = 0;
  int hold_seen = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    proj_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[160:0];
        if (exp_proj.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, got);
          errors++;
        end else begin
          want = exp_proj.pop_front();
          if (got.view_u !== want.view_u)
            $display("%0t: view_u exp %h got %h", $time, want.view_u, got.view_u);
          if (got.view_v !== want.view_v)
            $display("%0t: view_v exp %h got %h", $time, want.view_v, got.view_v);
          if (got.pix_x !== want.pix_x)
            $display("%0t: pixel_x exp %h got %h", $time, want.pix_x, got.pix_x);
          if (got.pix_y !== want.pix_y)
            $display("%0t: pixel_y exp %h got %h", $time, want.pix_y, got.pix_y);
          if (got.depth !== want.depth)
            $display("%0t: depth exp %h got %h", $time, want.depth, got.depth);
          if (got.behind !== want.behind)
            $display("%0t: not_in_front exp %b got %b", $time, want.behind, got.behind);
          if (got !== want) errors++;
        end
      end
      if (hold_seen != hold_req) begin
        hold_seen <= hold_req;
        hold_left <= 400;
        out_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_tready <= (hold_left == 1);
      end else if (stall > 0) begin
        stall <= stall - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (out_tvalid && out_tready) stall <= no_gaps ? 0 : $urandom_range(0, 5);
      end
    end
  end

  // Cycle limit.
  longint cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic reg_write(reg_idx_t idx, logic [63:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 6'(idx) << 3;
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      REG_CAM_X: cam_x = val[31:0];
      REG_CAM_Y: cam_y = val[31:0];
      REG_CAM_Z: cam_z = val[31:0];
      REG_FWD:   fwd_vec = val[62:0];
      REG_UP:    up_vec = val[62:0];
      REG_FOCAL: focal = val[23:0];
      REG_IMG_W: img_w = val[15:0];
      REG_IMG_H: img_h = val[15:0];
      default: ;
    endcase
  endtask

  // Wait for the pipeline to drain, then let it settle.
  task automatic drain();
    while (pend_points.size() > 0 || in_tvalid || exp_proj.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [62:0] vec3(int x, int y, int z);
    return {x[20:0], y[20:0], z[20:0]};
  endfunction

  // Mostly points near the camera with random content, some full-range noise.
  function automatic logic [95:0] rand_point();
    logic [31:0] c[3];
    c[0] = cam_x; c[1] = cam_y; c[2] = cam_z;
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(0, 3))
        0:       c[i] = $urandom();
        1:       c[i] = c[i] + ($urandom() >>> $urandom_range(0, 31)) - 32'h0800_0000;
        default: c[i] = c[i] + $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
      endcase
    end
    return {c[2], c[1], c[0]};
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      pend_points.push_back(rand_point());
    end
    drain();
  endtask

  initial begin
    cam_x = 0; cam_y = 0; cam_z = 0;
    fwd_vec = 63'd1572864;
    up_vec = 63'd1099511627776;
    focal = 24'd65536;
    img_w = 16'd640;
    img_h = 16'd480;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed points under the reset camera: in front, at the camera,
    // behind, field extremes and a huge quotient from a tiny depth.
    pend_points.push_back({-32'sd65536, 32'd0, 32'd0});
    pend_points.push_back('0);
    pend_points.push_back({32'sd65536, 32'd0, 32'd0});
    pend_points.push_back({-32'sd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    pend_points.push_back({-32'sd1, 32'h8000_0000, 32'h8000_0000});
    pend_points.push_back({32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
    pend_points.push_back({32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF});
    pend_points.push_back({32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000});
    pend_points.push_back({32'h8000_0000, 32'h0001_0000, 32'hFFFF_0000});
    pend_points.push_back({-32'sd131072, 32'h0000_8000, 32'hFFFF_8000});
    pend_points.push_back({-32'sd65536, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    drain();

    // Long receiver hold while the sender keeps offering points.
    hold_req++;
    random_phase(250);

    // Shifted camera, tilted axes, wide focal range and a one-pixel-wide, full-height image.
    reg_write(REG_CAM_X, 32'h0003_0000);
    reg_write(REG_CAM_Y, 32'hFFFE_8000);
    reg_write(REG_CAM_Z, 32'h000A_0000);
    reg_write(REG_FWD, vec3(0, -370728, -370728));
    reg_write(REG_UP, vec3(0, 370728, -370728));
    reg_write(REG_FOCAL, 24'h01_BB67);
    reg_write(REG_IMG_W, 16'd1);
    reg_write(REG_IMG_H, 16'd65535);
    random_phase(200);

    // Extreme camera position, non-unit vectors, full focal and image size.
    reg_write(REG_CAM_X, 32'h8000_0000);
    reg_write(REG_CAM_Y, 32'h7FFF_FFFF);
    reg_write(REG_CAM_Z, 32'h8000_0000);
    reg_write(REG_FWD, 63'h7FFF_FFFF_FFFF_FFFF);
    reg_write(REG_UP, vec3(-1048576, 1048575, 0));
    reg_write(REG_FOCAL, 24'hFF_FFFF);
    reg_write(REG_IMG_W, 16'hFFFF);
    reg_write(REG_IMG_H, 16'hFFFF);
    random_phase(200);

    // Zero focal length and zero image size.
    reg_write(REG_CAM_X, 32'd0);
    reg_write(REG_CAM_Y, 32'd0);
    reg_write(REG_CAM_Z, 32'd0);
    reg_write(REG_FWD, vec3(524288, 0, 0));
    reg_write(REG_UP, vec3(0, 0, 524288));
    reg_write(REG_FOCAL, 24'd0);
    reg_write(REG_IMG_W, 16'd0);
    reg_write(REG_IMG_H, 16'd0);
    random_phase(150);

    // Random vectors and settings.
    for (int k = 0; k < 3; k++) begin
      reg_write(REG_CAM_X, $urandom());
      reg_write(REG_CAM_Y, $urandom() >>> 8);
      reg_write(REG_CAM_Z, $urandom());
      reg_write(REG_FWD, {$urandom(), $urandom()});
      reg_write(REG_UP, {$urandom(), $urandom()});
      reg_write(REG_FOCAL, $urandom_range(1, 24'hFF_FFFF));
      reg_write(REG_IMG_W, $urandom_range(1, 16'hFFFF));
      reg_write(REG_IMG_H, $urandom_range(1, 16'hFFFF));
      random_phase(100);
    end

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
